FILE: rtl/core/aat_pkg.sv
package aat_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH   = COORD_WIDTH + 2;
    localparam int NUM_ENTRIES = 12;
    localparam int IDX_WIDTH   = 4;

    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_TRANSFORM = 1'b1;

    localparam logic signed [COORD_WIDTH-1:0] FX_ONE =
        COORD_WIDTH'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [COORD_WIDTH-1:0] C_MAX =
        {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN =
        {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [SUM_WIDTH-1:0]   t_sum;

    typedef struct packed {
        logic                 func;
        logic [IDX_WIDTH-1:0] entry_index;
        t_coord               entry_value;
        t_coord               box_min_x;
        t_coord               box_min_y;
        t_coord               box_min_z;
        t_coord               box_max_x;
        t_coord               box_max_y;
        t_coord               box_max_z;
    } t_in_beat;

    typedef struct packed {
        t_coord out_min_x;
        t_coord out_min_y;
        t_coord out_min_z;
        t_coord out_max_x;
        t_coord out_max_y;
        t_coord out_max_z;
    } t_out_beat;

    // floor(p / 2^FRAC_BITS), saturated to the coordinate range
    function automatic t_coord fx_floor_sat(input t_prod p);
        t_prod q;
        q = p >>> FRAC_BITS;
        if (q > PROD_WIDTH'(C_MAX)) begin
            return C_MAX;
        end else if (q < PROD_WIDTH'(C_MIN)) begin
            return C_MIN;
        end
        return q[COORD_WIDTH-1:0];
    endfunction

    function automatic t_coord fx_clamp(input t_sum s);
        if (s > SUM_WIDTH'(C_MAX)) begin
            return C_MAX;
        end else if (s < SUM_WIDTH'(C_MIN)) begin
            return C_MIN;
        end
        return s[COORD_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/core/aat_mul.sv
module aat_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  aat_pkg::t_in_beat  i_data,
    output logic               o_valid,
    output aat_pkg::t_prod     o_plo [3][3],
    output aat_pkg::t_prod     o_phi [3][3],
    output aat_pkg::t_coord    o_trans [3]
);

    aat_pkg::t_coord r_m [aat_pkg::NUM_ENTRIES];
    logic            r_v;
    aat_pkg::t_prod  r_plo [3][3];
    aat_pkg::t_prod  r_phi [3][3];
    aat_pkg::t_coord r_t [3];
    aat_pkg::t_coord lo [3];
    aat_pkg::t_coord hi [3];
    logic            acc;

    assign acc = i_en && i_valid;

    assign lo[0] = i_data.box_min_x;
    assign lo[1] = i_data.box_min_y;
    assign lo[2] = i_data.box_min_z;
    assign hi[0] = i_data.box_max_x;
    assign hi[1] = i_data.box_max_y;
    assign hi[2] = i_data.box_max_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < aat_pkg::NUM_ENTRIES; k++) begin
                r_m[k] <= ((k == 0) || (k == 5) || (k == 10)) ? aat_pkg::FX_ONE : '0;
            end
        end else if (acc && i_data.func == aat_pkg::FUNC_LOAD &&
                     i_data.entry_index < aat_pkg::IDX_WIDTH'(aat_pkg::NUM_ENTRIES)) begin
            r_m[i_data.entry_index] <= i_data.entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid && (i_data.func == aat_pkg::FUNC_TRANSFORM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_plo[r][c] <= aat_pkg::PROD_WIDTH'(r_m[r*4+c]) *
                                   aat_pkg::PROD_WIDTH'(lo[c]);
                    r_phi[r][c] <= aat_pkg::PROD_WIDTH'(r_m[r*4+c]) *
                                   aat_pkg::PROD_WIDTH'(hi[c]);
                end
                r_t[r] <= r_m[r*4+3];
            end
        end
    end

    assign o_valid = r_v;
    assign o_plo   = r_plo;
    assign o_phi   = r_phi;
    assign o_trans = r_t;

`ifndef SYNTHESIS
    a_load_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_data.func == aat_pkg::FUNC_LOAD) |=> !r_v)
        else $error("load produced a pipeline beat");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_v))
        else $error("stage valid moved while held");
    a_load_entry0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_data.func == aat_pkg::FUNC_LOAD && i_data.entry_index == '0)
        |=> r_m[0] == $past(i_data.entry_value))
        else $error("matrix entry not written");
`endif

endmodule

FILE: rtl/core/aat_sel.sv
module aat_sel (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  aat_pkg::t_prod  i_plo [3][3],
    input  aat_pkg::t_prod  i_phi [3][3],
    input  aat_pkg::t_coord i_trans [3],
    output logic            o_valid,
    output aat_pkg::t_coord o_mn [3][3],
    output aat_pkg::t_coord o_mx [3][3],
    output aat_pkg::t_coord o_trans [3]
);

    logic            r_v;
    aat_pkg::t_coord r_mn [3][3];
    aat_pkg::t_coord r_mx [3][3];
    aat_pkg::t_coord r_t [3];
    aat_pkg::t_coord qlo [3][3];
    aat_pkg::t_coord qhi [3][3];

    // each term is monotone in its coordinate, so the extremes of the
    // sum come from the per-term extremes
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                qlo[r][c] = aat_pkg::fx_floor_sat(i_plo[r][c]);
                qhi[r][c] = aat_pkg::fx_floor_sat(i_phi[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (qlo[r][c] < qhi[r][c]) begin
                        r_mn[r][c] <= qlo[r][c];
                        r_mx[r][c] <= qhi[r][c];
                    end else begin
                        r_mn[r][c] <= qhi[r][c];
                        r_mx[r][c] <= qlo[r][c];
                    end
                end
                r_t[r] <= i_trans[r];
            end
        end
    end

    assign o_valid = r_v;
    assign o_mn    = r_mn;
    assign o_mx    = r_mx;
    assign o_trans = r_t;

endmodule

FILE: rtl/core/aat_sum.sv
module aat_sum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  aat_pkg::t_coord    i_mn [3][3],
    input  aat_pkg::t_coord    i_mx [3][3],
    input  aat_pkg::t_coord    i_trans [3],
    output logic               o_valid,
    output aat_pkg::t_out_beat o_data
);

    logic               r_v;
    aat_pkg::t_out_beat r_out;
    aat_pkg::t_coord    smn [3];
    aat_pkg::t_coord    smx [3];
    aat_pkg::t_sum      amn;
    aat_pkg::t_sum      amx;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            amn = aat_pkg::SUM_WIDTH'(i_mn[r][0]) + aat_pkg::SUM_WIDTH'(i_mn[r][1])
                + aat_pkg::SUM_WIDTH'(i_mn[r][2]) + aat_pkg::SUM_WIDTH'(i_trans[r]);
            amx = aat_pkg::SUM_WIDTH'(i_mx[r][0]) + aat_pkg::SUM_WIDTH'(i_mx[r][1])
                + aat_pkg::SUM_WIDTH'(i_mx[r][2]) + aat_pkg::SUM_WIDTH'(i_trans[r]);
            smn[r] = aat_pkg::fx_clamp(amn);
            smx[r] = aat_pkg::fx_clamp(amx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.out_min_x <= smn[0];
            r_out.out_min_y <= smn[1];
            r_out.out_min_z <= smn[2];
            r_out.out_max_x <= smx[0];
            r_out.out_max_y <= smx[1];
            r_out.out_max_z <= smx[2];
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_out;

endmodule

FILE: rtl/core/aabb_affine_transform_top.sv
// A transform beat passes the multiply, select and sum register stages before it shows at the output.
// Throughput: one beat per cycle while the output is not stalled; loads give no result.
// A load updates the matrix at its acceptance edge, so the very next beat
// sees it. The pipeline holds as a whole while the output beat is stalled.
// Reset: pipeline valids clear, matrix returns to the identity.
module aabb_affine_transform_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  aat_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output aat_pkg::t_out_beat o_data
);

    logic            en;
    logic            v1;
    logic            v2;
    aat_pkg::t_prod  plo [3][3];
    aat_pkg::t_prod  phi [3][3];
    aat_pkg::t_coord t1 [3];
    aat_pkg::t_coord mn [3][3];
    aat_pkg::t_coord mx [3][3];
    aat_pkg::t_coord t2 [3];

    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    aat_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (v1),
        .o_plo   (plo),
        .o_phi   (phi),
        .o_trans (t1)
    );

    aat_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_plo   (plo),
        .i_phi   (phi),
        .i_trans (t1),
        .o_valid (v2),
        .o_mn    (mn),
        .o_mx    (mx),
        .o_trans (t2)
    );

    aat_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v2),
        .i_mn    (mn),
        .i_mx    (mx),
        .i_trans (t2),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule
